// ===== src/f2ss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// f2ss_pkg: shared definitions for the fixed-point to seven-segment block
// Widths, decimal limits, glyph encoding and the double-dabble digit fix-up
// used by the converter and the top level.
// ----------------------------------------------------------------------------
package f2ss_pkg;

  // Field widths.
  localparam int MAG_W  = 38;
  localparam int UNIT_W = 4;
  localparam int SEG_W  = 7;

  // The binary to BCD converter sees the magnitude without its top bit; any
  // magnitude that needs that bit is out of range anyway.
  localparam int BIN_W   = MAG_W - 1;
  localparam int NUM_DEC = 12;
  localparam int BCD_W   = 4 * NUM_DEC;

  // Conversion steps handled in one pipeline stage.
  localparam int STEPS_PER_STAGE = 8;
  localparam int CONV_STAGES     = (BIN_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // Display has eight digits; rounding drops the three fractional digits.
  localparam int NUM_DISP   = 8;
  localparam int FRAC_DIGITS = 3;

  // Decimal limits on the magnitude in thousandths.
  localparam logic [MAG_W-1:0] POS_RANGE_LIMIT = MAG_W'(64'd99999999000);
  localparam logic [MAG_W-1:0] NEG_RANGE_LIMIT = MAG_W'(64'd100000000);
  localparam logic [MAG_W-1:0] POS_POINT_LIMIT = MAG_W'(64'd100000000);
  localparam logic [MAG_W-1:0] NEG_POINT_LIMIT = MAG_W'(64'd10000000);
  localparam logic [MAG_W-1:0] PAD_LIMIT       = MAG_W'(64'd1000);

  // Glyph codes beyond the decimal digits.
  localparam logic [3:0] GLYPH_DASH  = 4'd10;
  localparam logic [3:0] GLYPH_BLANK = 4'd11;

  // Sideband that travels beside the converter.
  typedef struct packed {
    logic              neg;
    logic              in_range;
    logic              dot;
    logic              pad;
    logic [UNIT_W-1:0] unit;
  } side_t;

  // Add three to every BCD digit that is five or more, ahead of a shift.
  function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
    logic [BCD_W-1:0] res;
    res = bcd;
    for (int i = 0; i < NUM_DEC; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return res;
  endfunction

  // Segment pattern of a glyph: bits 6-3 DEFA, bits 2-0 CGB.
  function automatic logic [SEG_W-1:0] glyph_seg(input logic [3:0] glyph);
    logic [SEG_W-1:0] seg;
    unique case (glyph)
      4'd0:       seg = 7'h7D;
      4'd1:       seg = 7'h05;
      4'd2:       seg = 7'h6B;
      4'd3:       seg = 7'h4F;
      4'd4:       seg = 7'h17;
      4'd5:       seg = 7'h5E;
      4'd6:       seg = 7'h7E;
      4'd7:       seg = 7'h0D;
      4'd8:       seg = 7'h7F;
      4'd9:       seg = 7'h5F;
      GLYPH_DASH: seg = 7'h02;
      default:    seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

// ===== src/fixed_point_to_seven_segment.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_to_seven_segment: signed thousandths to eight-digit display
// Converts a signed value in thousandths into eight seven-segment codes,
// the decimal point, a copy of the unit code and an out-of-range flag.
// ----------------------------------------------------------------------------
// The block takes one value on every clock cycle: busy stays low, so a value
// is taken at every edge where start is high. Each result appears on the
// outputs as a one-cycle beat marked by done_o; results keep the order of the
// values and the receiver cannot hold them off. The pipeline has one stage for
// the sign and magnitude, five stages for the 37-bit binary to decimal
// conversion (eight bit steps each, five in the last), one for rounding to
// whole units and one for blanking, sign placement and segment encoding.
// ----------------------------------------------------------------------------
module fixed_point_to_seven_segment (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [f2ss_pkg::MAG_W-1:0] value_milli_i,
  input  wire logic [f2ss_pkg::UNIT_W-1:0]       unit_code_i,
  output logic                                   done_o,
  output logic [f2ss_pkg::SEG_W-1:0]             seg_digit_0_o,
  output logic [f2ss_pkg::SEG_W-1:0]             seg_digit_1_o,
  output logic [f2ss_pkg::SEG_W-1:0]             seg_digit_2_o,
  output logic [f2ss_pkg::SEG_W-1:0]             seg_digit_3_o,
  output logic [f2ss_pkg::SEG_W-1:0]             seg_digit_4_o,
  output logic [f2ss_pkg::SEG_W-1:0]             seg_digit_5_o,
  output logic [f2ss_pkg::SEG_W-1:0]             seg_digit_6_o,
  output logic [f2ss_pkg::SEG_W-1:0]             seg_digit_7_o,
  output logic                                   point_on_o,
  output logic [f2ss_pkg::UNIT_W-1:0]            unit_out_o,
  output logic                                   out_of_range_o
);
  import f2ss_pkg::*;

  localparam int ShownW = 4 * NUM_DISP;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // Stage 1: sign and magnitude.
  // --------------------------------------------------------------------------
  logic              vld1_q;
  logic              neg1_q;
  logic [MAG_W-1:0]  mag1_q;
  logic [UNIT_W-1:0] unit1_q;
  logic [MAG_W-1:0]  raw_u;
  logic [MAG_W-1:0]  mag1_d;

  assign raw_u  = MAG_W'(value_milli_i);
  assign mag1_d = raw_u[MAG_W-1] ? MAG_W'(~raw_u + 1'b1) : raw_u;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q  <= raw_u[MAG_W-1];
    mag1_q  <= mag1_d;
    unit1_q <= unit_code_i;
  end

  // --------------------------------------------------------------------------
  // Range and format decisions, carried beside the converter.
  // --------------------------------------------------------------------------
  side_t side_d;
  side_t side_q [CONV_STAGES];

  always_comb begin
    side_d.neg      = neg1_q;
    side_d.in_range = neg1_q ? (mag1_q < NEG_RANGE_LIMIT) : (mag1_q < POS_RANGE_LIMIT);
    side_d.dot      = neg1_q ? (mag1_q < NEG_POINT_LIMIT) : (mag1_q < POS_POINT_LIMIT);
    side_d.pad      = mag1_q < PAD_LIMIT;
    side_d.unit     = unit1_q;
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int s = 1; s < CONV_STAGES; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  // --------------------------------------------------------------------------
  // Binary to BCD conversion.
  // --------------------------------------------------------------------------
  logic             vldc;
  logic [BCD_W-1:0] bcdc;

  f2ss_bin2bcd u_bin2bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld1_q),
    .bin_i   (mag1_q[BIN_W-1:0]),
    .valid_o (vldc),
    .bcd_o   (bcdc)
  );

  // --------------------------------------------------------------------------
  // Rounding stage: keep all digits with three decimals, or round half up to
  // whole units by a decimal increment of the integer digits.
  // --------------------------------------------------------------------------
  logic              vldr_q;
  side_t             sider_q;
  logic [ShownW-1:0] shownr_q;
  logic [ShownW-1:0] rounded;
  logic [ShownW-1:0] shownr_d;

  always_comb begin
    logic       carry;
    logic [3:0] dig;
    carry   = bcdc[4*(FRAC_DIGITS-1) +: 4] >= 4'd5;
    rounded = '0;
    dig     = '0;
    for (int i = 0; i < NUM_DISP; i++) begin
      dig = bcdc[4*(i+FRAC_DIGITS) +: 4];
      if (carry && dig == 4'd9) begin
        rounded[4*i +: 4] = 4'd0;
      end else begin
        rounded[4*i +: 4] = dig + {3'd0, carry};
        carry             = 1'b0;
      end
    end
    shownr_d = side_q[CONV_STAGES-1].dot ? bcdc[ShownW-1:0] : rounded;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldr_q <= 1'b0;
    end else begin
      vldr_q <= vldc;
    end
  end

  always_ff @(posedge clk_i) begin
    sider_q  <= side_q[CONV_STAGES-1];
    shownr_q <= shownr_d;
  end

  // --------------------------------------------------------------------------
  // Format stage: blank leading zeros, pad below one, place the minus and
  // encode the segments. Digit 0 of the value is the rightmost position and drives seg_digit_7_o.
  // --------------------------------------------------------------------------
  logic [NUM_DISP-1:0] show;
  logic [SEG_W-1:0]    seg_d [NUM_DISP];

  always_comb begin
    logic             sig;
    logic [3:0]       glyph;
    logic [3:0]       dig;
    logic             minus;
    sig   = 1'b0;
    glyph = GLYPH_BLANK;
    dig   = '0;
    minus = 1'b0;
    show  = '0;
    for (int i = NUM_DISP - 1; i >= 0; i--) begin
      sig     = sig | (shownr_q[4*i +: 4] != 4'd0);
      show[i] = sig || (i == 0) || (sider_q.pad && i < 4);
    end
    for (int i = 0; i < NUM_DISP; i++) begin
      dig   = shownr_q[4*i +: 4];
      minus = (i > 0) && sider_q.neg && !show[i] && show[(i > 0) ? i - 1 : 0];
      if (!sider_q.in_range) begin
        glyph = GLYPH_DASH;
      end else if (show[i]) begin
        glyph = dig;
      end else if (minus) begin
        glyph = GLYPH_DASH;
      end else begin
        glyph = GLYPH_BLANK;
      end
      seg_d[NUM_DISP-1-i] = glyph_seg(glyph);
    end
  end

  // Output registers.
  logic              done_q;
  logic [SEG_W-1:0]  seg_q [NUM_DISP];
  logic              point_q;
  logic [UNIT_W-1:0] unit_q;
  logic              oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vldr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_DISP; k++) begin
      seg_q[k] <= seg_d[k];
    end
    point_q <= sider_q.in_range & sider_q.dot;
    unit_q  <= sider_q.unit;
    oor_q   <= ~sider_q.in_range;
  end

  assign done_o         = done_q;
  assign seg_digit_0_o  = seg_q[0];
  assign seg_digit_1_o  = seg_q[1];
  assign seg_digit_2_o  = seg_q[2];
  assign seg_digit_3_o  = seg_q[3];
  assign seg_digit_4_o  = seg_q[4];
  assign seg_digit_5_o  = seg_q[5];
  assign seg_digit_6_o  = seg_q[6];
  assign seg_digit_7_o  = seg_q[7];
  assign point_on_o     = point_q;
  assign unit_out_o     = unit_q;
  assign out_of_range_o = oor_q;

endmodule
`default_nettype wire

// ===== src/f2ss_bin2bcd.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// f2ss_bin2bcd: pipelined binary to BCD converter
// Shift-and-add-three conversion of the magnitude, up to STEPS_PER_STAGE bit
// steps per register stage, with a valid bit travelling alongside.
// ----------------------------------------------------------------------------
module f2ss_bin2bcd (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire logic [f2ss_pkg::BIN_W-1:0] bin_i,
  output logic                            valid_o,
  output logic [f2ss_pkg::BCD_W-1:0]      bcd_o
);
  import f2ss_pkg::*;

  logic [CONV_STAGES-1:0] vld_q;
  logic [BCD_W-1:0]       bcd_q [CONV_STAGES];
  logic [BIN_W-1:0]       bin_q [CONV_STAGES-1];

  for (genvar s = 0; s < CONV_STAGES; s++) begin : g_stage
    localparam int First  = s * STEPS_PER_STAGE;
    localparam int NSteps = (BIN_W - First < STEPS_PER_STAGE) ?
                            (BIN_W - First) : STEPS_PER_STAGE;

    logic [BCD_W-1:0] bcd_in, bcd_d;
    logic [BIN_W-1:0] bin_in, bin_d;
    logic             vld_in;

    // Stage input: fresh operand at the head, previous stage otherwise.
    if (s == 0) begin : g_head
      assign bcd_in = '0;
      assign bin_in = bin_i;
      assign vld_in = valid_i;
    end else begin : g_body
      assign bcd_in = bcd_q[s-1];
      assign bin_in = bin_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    // This stage's share of the bit steps: fix up the digits, then shift.
    always_comb begin
      logic [BCD_W-1:0] adj;
      bcd_d = bcd_in;
      bin_d = bin_in;
      adj   = '0;
      for (int k = 0; k < NSteps; k++) begin
        adj   = bcd_adjust(bcd_d);
        bcd_d = {adj[BCD_W-2:0], bin_d[BIN_W-1]};
        bin_d = {bin_d[BIN_W-2:0], 1'b0};
      end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    // Partial result of the stage.
    always_ff @(posedge clk_i) begin
      bcd_q[s] <= bcd_d;
    end

    // Remaining binary bits, needed by all but the last stage.
    if (s < CONV_STAGES - 1) begin : g_bin
      always_ff @(posedge clk_i) begin
        bin_q[s] <= bin_d;
      end
    end
  end

  assign valid_o = vld_q[CONV_STAGES-1];
  assign bcd_o   = bcd_q[CONV_STAGES-1];

endmodule
`default_nettype wire
